FILE: src/hbq_pkg.sv
// Held batch queue package: action and result codes, widths, reset values,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package hbq_pkg;

  localparam int ACTION_W    = 2;
  localparam int KIND_W      = 2;
  localparam int LIMIT_W     = 5;
  localparam int HOLD_W      = 8;
  localparam int PORT_DATA_W = 32;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [KIND_W-1:0]   kind_t;

  // Input actions; the fourth code is unused and ignored.
  localparam action_t ACT_ENQUEUE = 2'd0;
  localparam action_t ACT_HOLD    = 2'd1;
  localparam action_t ACT_RELEASE = 2'd2;

  // Result kinds.
  localparam kind_t KIND_OK      = 2'd0;
  localparam kind_t KIND_REJECT  = 2'd1;
  localparam kind_t KIND_DRAINED = 2'd2;
  localparam kind_t KIND_EMPTY   = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [HOLD_W-1:0]  HOLD_MAX    = 8'hFF;

  typedef struct packed {
    logic    accept;
    action_t action;
    logic    drain_read;
    logic    drain_emit;
  } hbq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic release_drains;
    logic drain_last;
  } hbq_status_t;

endpackage

FILE: src/hbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/hbq_datapath.sv
// Held batch queue datapath: limit register, hold level, fill counters,
// the two entry stores, drain pointer and the result register.
// Depends on hbq_pkg and hbq_ram.
module hbq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hbq_pkg::LIMIT_W-1:0]         cfg_limit,
  input  hbq_pkg::hbq_cmd_t                   cmd,
  output hbq_pkg::hbq_status_t                status,
  input  logic [hbq_pkg::PORT_DATA_W-1:0]     entry_data,
  input  logic                                result_stall,
  output logic                                result_valid,
  output hbq_pkg::kind_t                      result_kind,
  output logic [hbq_pkg::PORT_DATA_W-1:0]     drained_data,
  output logic                                last
);

  localparam int SW = (DATA_WIDTH < hbq_pkg::PORT_DATA_W) ? DATA_WIDTH : hbq_pkg::PORT_DATA_W;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (FW > hbq_pkg::LIMIT_W) ? FW : hbq_pkg::LIMIT_W;

  logic [hbq_pkg::LIMIT_W-1:0] limit;
  logic [hbq_pkg::HOLD_W-1:0]  hold_level;
  logic [FW-1:0]               active_fill;
  logic [FW-1:0]               pending_fill;
  logic [AW-1:0]               idx;
  logic                        sel;

  logic [FW-1:0] cur_fill;
  logic [FW-1:0] idx_inc;
  logic          held;
  logic          full;
  logic          seg_end;
  logic          enq_ok;
  logic          load_result;
  logic [SW-1:0] rd_active;
  logic [SW-1:0] rd_pending;
  logic [SW-1:0] rd_data;

  assign held     = (hold_level != '0);
  assign cur_fill = held ? pending_fill : active_fill;
  assign full     = (CW'(cur_fill) >= CW'(limit)) || (cur_fill >= FW'(DEPTH));
  assign enq_ok   = cmd.accept && (cmd.action == hbq_pkg::ACT_ENQUEUE) && !full;
  assign idx_inc  = FW'(idx) + FW'(1);
  assign seg_end  = sel ? (idx_inc == pending_fill) : (idx_inc == active_fill);
  assign rd_data  = sel ? rd_pending : rd_active;

  // Load the result register for a drained entry or any item that answers at once.
  assign load_result = cmd.drain_emit ||
                       (cmd.accept &&
                        ((cmd.action inside {hbq_pkg::ACT_ENQUEUE, hbq_pkg::ACT_HOLD}) ||
                         ((cmd.action == hbq_pkg::ACT_RELEASE) && !status.release_drains)));

  assign status.out_free       = !result_valid || !result_stall;
  assign status.release_drains = (hold_level[hbq_pkg::HOLD_W-1:1] == '0) &&
                                 ((active_fill != '0) || (pending_fill != '0));
  assign status.drain_last     = seg_end && (sel || (pending_fill == '0));

  hbq_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_active_ram (
    .clk   (clk),
    .we    (enq_ok && !held),
    .waddr (active_fill[AW-1:0]),
    .wdata (entry_data[SW-1:0]),
    .re    (cmd.drain_read && !sel),
    .raddr (idx),
    .rdata (rd_active)
  );

  hbq_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_pending_ram (
    .clk   (clk),
    .we    (enq_ok && held),
    .waddr (pending_fill[AW-1:0]),
    .wdata (entry_data[SW-1:0]),
    .re    (cmd.drain_read && sel),
    .raddr (idx),
    .rdata (rd_pending)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit        <= hbq_pkg::LIMIT_RESET;
      hold_level   <= '0;
      active_fill  <= '0;
      pending_fill <= '0;
      idx          <= '0;
      sel          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        limit <= cfg_limit;
      end
      if (cmd.accept) begin
        case (cmd.action)
          hbq_pkg::ACT_ENQUEUE: begin
            result_kind  <= full ? hbq_pkg::KIND_REJECT : hbq_pkg::KIND_OK;
            drained_data <= '0;
            last         <= 1'b1;
            if (!full) begin
              if (held) begin
                pending_fill <= pending_fill + FW'(1);
              end else begin
                active_fill <= active_fill + FW'(1);
              end
            end
          end
          hbq_pkg::ACT_HOLD: begin
            if (hold_level != hbq_pkg::HOLD_MAX) begin
              hold_level <= hold_level + hbq_pkg::HOLD_W'(1);
            end
            result_kind  <= hbq_pkg::KIND_OK;
            drained_data <= '0;
            last         <= 1'b1;
          end
          hbq_pkg::ACT_RELEASE: begin
            if (hold_level[hbq_pkg::HOLD_W-1:1] != '0) begin
              hold_level   <= hold_level - hbq_pkg::HOLD_W'(1);
              result_kind  <= hbq_pkg::KIND_OK;
              drained_data <= '0;
              last         <= 1'b1;
            end else begin
              hold_level <= '0;
              if (status.release_drains) begin
                sel <= (active_fill == '0);
                idx <= '0;
              end else begin
                result_kind  <= hbq_pkg::KIND_EMPTY;
                drained_data <= '0;
                last         <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.drain_emit) begin
        result_kind  <= hbq_pkg::KIND_DRAINED;
        drained_data <= hbq_pkg::PORT_DATA_W'(rd_data);
        last         <= status.drain_last;
        if (status.drain_last) begin
          active_fill  <= '0;
          pending_fill <= '0;
        end else if (seg_end) begin
          sel <= 1'b1;
          idx <= '0;
        end else begin
          idx <= idx + AW'(1);
        end
      end
    end
  end

  a_active_fill_bound: assert property (@(posedge clk) disable iff (rst)
    active_fill <= FW'(DEPTH) && pending_fill <= FW'(DEPTH))
    else $error("fill count beyond store depth");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept || cmd.drain_emit) |-> status.out_free)
    else $error("result register overwritten while stalled");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.drain_emit && status.drain_last) |=> (active_fill == '0 && pending_fill == '0))
    else $error("stores not emptied after final drained entry");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_read |-> (sel ? (pending_fill != '0) : (active_fill != '0)))
    else $error("drain read from an empty store");

endmodule

FILE: src/hbq_ctrl.sv
// Held batch queue controller: takes items and sequences the drain walk.
// Depends on hbq_pkg.
module hbq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  hbq_pkg::action_t      action,
  input  hbq_pkg::hbq_status_t  status,
  output hbq_pkg::hbq_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = !status.out_free;
        cmd.accept = item_valid && status.out_free;
        cmd.action = action;
      end
      ST_READ: cmd.drain_read = 1'b1;
      ST_EMIT: cmd.drain_emit = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.accept && (action == hbq_pkg::ACT_RELEASE) && status.release_drains) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_EMIT;
        ST_EMIT: begin
          if (cmd.drain_emit) begin
            state <= status.drain_last ? ST_IDLE : ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (item_stall && !cmd.accept))
    else $error("item taken during drain");

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_EMIT))
    else $error("drain read not followed by emit");

  a_emit_stays: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !status.out_free) |=> (state == ST_EMIT))
    else $error("drained entry lost under stall");

endmodule

FILE: src/held_batch_queue_top.sv
// Held batch queue top level: ports, configuration write channel, and the
// controller/datapath pair. Depends on hbq_pkg, hbq_ctrl, hbq_datapath.
//
// Usage:
//   Item channel (item_valid/item_stall, action, entry_data): one transfer
//   per item. Enqueue stores entry_data in the active store, or in the
//   pending store while a hold is in effect; hold raises the hold level;
//   release lowers it and, when it reaches zero, drains both stores.
//   Result channel (result_valid/result_stall, result_kind, drained_data,
//   last): enqueue, hold and a still-held release give one result, in the
//   cycle after the item transfer. A draining release gives one result per
//   stored entry (active first, then pending); each passes the ST_READ
//   state (store RAM read) and then the ST_EMIT state (result register
//   load), and ST_EMIT waits while the result side is stalled; last marks
//   the final one. An empty drain gives one "nothing drained" result.
//   Throughput: one item per cycle for non-draining items with the result
//   side free; a drain holds off new items until its last entry is emitted.
//   Config channel (cfg_valid/cfg_ready, queue_limit): always ready; write
//   only while no item is in flight.
//   Reset (synchronous, rst): hold level and fill counts clear, limit = 16,
//   no result pending. Store contents are not cleared.
//   Receiver stall: the result register holds; item_stall rises until the
//   waiting result transfers, and a drain pauses in place.
module held_batch_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbq_pkg::LIMIT_W-1:0]       queue_limit,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [hbq_pkg::ACTION_W-1:0]      action,
  input  logic [hbq_pkg::PORT_DATA_W-1:0]   entry_data,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [hbq_pkg::KIND_W-1:0]        result_kind,
  output logic [hbq_pkg::PORT_DATA_W-1:0]   drained_data,
  output logic                              last
);

  hbq_pkg::hbq_cmd_t    cmd;
  hbq_pkg::hbq_status_t status;

  // Limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  hbq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .status     (status),
    .cmd        (cmd)
  );

  hbq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_limit    (queue_limit),
    .cmd          (cmd),
    .status       (status),
    .entry_data   (entry_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .drained_data (drained_data),
    .last         (last)
  );

endmodule
